/* rtl/core/ir_frame_pulse_distance_tx_macros.svh */
// Assertion macros used by the envelope sequencer (ifpd_seq).
`ifndef IR_FRAME_PULSE_DISTANCE_TX_MACROS_SVH
`define IR_FRAME_PULSE_DISTANCE_TX_MACROS_SVH

// Same-cycle implication, held off during reset.
`define IFPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifpd assertion failed");

// Next-cycle implication, held off during reset.
`define IFPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifpd assertion failed");

`endif

/* rtl/core/ifpd_pkg.sv */
// Types, constants and helper functions of the IR frame transmitter.
package ifpd_pkg;

    localparam int FRAME_BYTES = 14;

    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_byte_pos;
    typedef logic [2:0]  t_bit_pos;
    typedef logic [15:0] t_ticks;
    typedef logic [2:0]  t_cfg_idx;

    localparam t_byte_pos POWER_POS = 4'd5;
    localparam t_byte_pos MODE_POS  = 4'd6;
    localparam t_byte_pos TEMP_POS  = 4'd7;
    localparam t_byte_pos FAN_POS   = 4'd8;
    localparam t_byte_pos LAST_POS  = t_byte_pos'(FRAME_BYTES - 1);
    localparam t_bit_pos  BIT_MSB   = 3'd7;

    localparam t_byte FRAME_TEMPLATE [FRAME_BYTES] = '{
        8'hC4, 8'hD3, 8'h64, 8'h80, 8'h00, 8'h00, 8'h00,
        8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h6A
    };

    // Register indexes on the configuration port.
    localparam t_cfg_idx CFG_HDR_MARK  = 3'd0;
    localparam t_cfg_idx CFG_HDR_SPACE = 3'd1;
    localparam t_cfg_idx CFG_BIT_MARK  = 3'd2;
    localparam t_cfg_idx CFG_ONE_SPACE = 3'd3;
    localparam t_cfg_idx CFG_ZERO_SPACE = 3'd4;

    localparam t_ticks RST_HDR_MARK   = 16'd3000;
    localparam t_ticks RST_HDR_SPACE  = 16'd3000;
    localparam t_ticks RST_BIT_MARK   = 16'd500;
    localparam t_ticks RST_ONE_SPACE  = 16'd1100;
    localparam t_ticks RST_ZERO_SPACE = 16'd500;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_END_MARK
    } t_phase;

    typedef struct packed {
        t_ticks hdr_mark;
        t_ticks hdr_space;
        t_ticks bit_mark;
        t_ticks one_space;
        t_ticks zero_space;
    } t_timing;

    typedef struct packed {
        logic      load;
        t_byte_pos byte_pos;
        t_bit_pos  bit_pos;
    } t_frame_ctl;

    typedef struct packed {
        logic ir_mark;
        logic busy_res;
        logic frame_done;
    } t_result;

    function automatic t_byte bit_rev8(input t_byte v);
        t_byte r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = v[k];
        end
        return r;
    endfunction

    // Sum of the bit-reversed fixed template bytes, folded at elaboration.
    function automatic t_byte template_sum();
        t_byte s;
        s = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            if (i != int'(POWER_POS) && i != int'(MODE_POS) &&
                i != int'(TEMP_POS) && i != int'(FAN_POS)) begin
                s = s + bit_rev8(FRAME_TEMPLATE[i]);
            end
        end
        return s;
    endfunction

    localparam t_byte CSUM_BASE = template_sum();

endpackage

/* rtl/core/ifpd_frame.sv */
// Frame store: builds the 14-byte frame with checksum and serves the current bit.
module ifpd_frame (
    input  logic                i_clk,
    input  ifpd_pkg::t_frame_ctl i_ctl,
    input  ifpd_pkg::t_byte     i_power_byte,
    input  ifpd_pkg::t_byte     i_mode_byte,
    input  ifpd_pkg::t_byte     i_temp_byte,
    input  ifpd_pkg::t_byte     i_fan_byte,
    output logic                o_cur_bit
);

    ifpd_pkg::t_byte r_frame [ifpd_pkg::FRAME_BYTES];
    ifpd_pkg::t_byte n_frame [ifpd_pkg::FRAME_BYTES];
    ifpd_pkg::t_byte sum;

    always_comb begin
        sum = ifpd_pkg::CSUM_BASE
            + ifpd_pkg::bit_rev8(i_power_byte) + ifpd_pkg::bit_rev8(i_mode_byte)
            + ifpd_pkg::bit_rev8(i_temp_byte) + ifpd_pkg::bit_rev8(i_fan_byte);
        n_frame = ifpd_pkg::FRAME_TEMPLATE;
        n_frame[ifpd_pkg::POWER_POS] = i_power_byte;
        n_frame[ifpd_pkg::MODE_POS]  = i_mode_byte;
        n_frame[ifpd_pkg::TEMP_POS]  = i_temp_byte;
        n_frame[ifpd_pkg::FAN_POS]   = i_fan_byte;
        n_frame[ifpd_pkg::LAST_POS]  = ifpd_pkg::bit_rev8(sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frame <= n_frame;
        end
    end

    assign o_cur_bit = r_frame[i_ctl.byte_pos][i_ctl.bit_pos];

endmodule

/* rtl/core/ifpd_seq.sv */
// Envelope sequencer: phase machine, bit and byte positions, tick counter.
`include "ir_frame_pulse_distance_tx_macros.svh"
module ifpd_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_action,
    input  ifpd_pkg::t_timing    i_timing,
    input  logic                 i_cur_bit,
    output ifpd_pkg::t_frame_ctl o_frame_ctl,
    output ifpd_pkg::t_result    o_result
);

    ifpd_pkg::t_phase    r_phase, n_phase;
    ifpd_pkg::t_byte_pos r_byte_pos, n_byte_pos;
    ifpd_pkg::t_bit_pos  r_bit_pos, n_bit_pos;
    ifpd_pkg::t_ticks    r_tick, n_tick;

    logic             busy;
    logic             load;
    logic             seg_last;
    ifpd_pkg::t_ticks seg_len;
    logic             seg_mark;

    assign busy = (r_phase != ifpd_pkg::PH_IDLE);
    assign load = i_step && i_action && !busy;

    assign o_frame_ctl.load     = load;
    assign o_frame_ctl.byte_pos = r_byte_pos;
    assign o_frame_ctl.bit_pos  = r_bit_pos;

    // Output logic: segment level and length, result of this request.
    always_comb begin
        case (r_phase)
            ifpd_pkg::PH_HDR_MARK: begin
                seg_mark = 1'b1;
                seg_len  = i_timing.hdr_mark;
            end
            ifpd_pkg::PH_HDR_SPACE: begin
                seg_mark = 1'b0;
                seg_len  = i_timing.hdr_space;
            end
            ifpd_pkg::PH_BIT_MARK: begin
                seg_mark = 1'b1;
                seg_len  = i_timing.bit_mark;
            end
            ifpd_pkg::PH_BIT_SPACE: begin
                seg_mark = 1'b0;
                seg_len  = i_cur_bit ? i_timing.one_space : i_timing.zero_space;
            end
            default: begin
                seg_mark = 1'b1;
                seg_len  = i_timing.bit_mark;
            end
        endcase
        // A zero length ends the segment after one tick, like a length of one.
        seg_last = ({1'b0, r_tick} + 17'd1) >= {1'b0, seg_len};

        if (i_action) begin
            o_result = '{ir_mark: 1'b0, busy_res: 1'b1, frame_done: 1'b0};
        end else if (!busy) begin
            o_result = '0;
        end else begin
            o_result.ir_mark    = seg_mark;
            o_result.busy_res   = 1'b1;
            o_result.frame_done = seg_last && (r_phase == ifpd_pkg::PH_END_MARK);
        end
    end

    // Next-state logic.
    always_comb begin
        n_phase    = r_phase;
        n_byte_pos = r_byte_pos;
        n_bit_pos  = r_bit_pos;
        n_tick     = r_tick;
        if (load) begin
            n_phase    = ifpd_pkg::PH_HDR_MARK;
            n_byte_pos = '0;
            n_bit_pos  = ifpd_pkg::BIT_MSB;
            n_tick     = '0;
        end else if (i_step && !i_action && busy) begin
            if (!seg_last) begin
                n_tick = r_tick + 16'd1;
            end else begin
                n_tick = '0;
                case (r_phase)
                    ifpd_pkg::PH_HDR_MARK:  n_phase = ifpd_pkg::PH_HDR_SPACE;
                    ifpd_pkg::PH_HDR_SPACE: n_phase = ifpd_pkg::PH_BIT_MARK;
                    ifpd_pkg::PH_BIT_MARK:  n_phase = ifpd_pkg::PH_BIT_SPACE;
                    ifpd_pkg::PH_BIT_SPACE: begin
                        if (r_bit_pos != 3'd0) begin
                            n_bit_pos = r_bit_pos - 3'd1;
                            n_phase   = ifpd_pkg::PH_BIT_MARK;
                        end else if (r_byte_pos != ifpd_pkg::LAST_POS) begin
                            n_byte_pos = r_byte_pos + 4'd1;
                            n_bit_pos  = ifpd_pkg::BIT_MSB;
                            n_phase    = ifpd_pkg::PH_BIT_MARK;
                        end else begin
                            n_phase = ifpd_pkg::PH_END_MARK;
                        end
                    end
                    default: begin
                        n_phase    = ifpd_pkg::PH_IDLE;
                        n_byte_pos = '0;
                        n_bit_pos  = ifpd_pkg::BIT_MSB;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ifpd_pkg::PH_IDLE;
            r_byte_pos <= '0;
            r_bit_pos  <= ifpd_pkg::BIT_MSB;
            r_tick     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_pos <= n_byte_pos;
            r_bit_pos  <= n_bit_pos;
            r_tick     <= n_tick;
        end
    end

    `IFPD_ASSERT_NOW(a_idle_tick_zero, i_clk, i_rst_n,
        r_phase == ifpd_pkg::PH_IDLE, r_tick == '0)
    `IFPD_ASSERT_NOW(a_byte_in_frame, i_clk, i_rst_n,
        1'b1, r_byte_pos <= ifpd_pkg::LAST_POS)
    `IFPD_ASSERT_NEXT(a_start_enters_header, i_clk, i_rst_n,
        load, r_phase == ifpd_pkg::PH_HDR_MARK && r_tick == '0)
    `IFPD_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n,
        i_step && o_result.frame_done, r_phase == ifpd_pkg::PH_IDLE)

endmodule

/* rtl/core/ir_frame_pulse_distance_tx.sv */
// Top level of the IR pulse-distance frame transmitter.
// Input channel (i_in_valid / o_in_stall) carries one request per cycle while
//   not stalled: i_action = 1 starts a frame with the four command bytes when
//   idle, i_action = 0 is one microsecond tick of the envelope.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   request: carrier level, busy flag and end-of-frame strobe.
// A result appears in the cycle after its request is accepted; one request is
//   taken every cycle unless stalled. The per-request work is a single pass
//   through the phase machine and frame store, closed by the result register.
// When the receiver stalls, the result register holds its result and
//   o_in_stall rises, so no new request enters until the result is taken.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
//   writes the five segment lengths; indexes above four are dropped.
// Reset (synchronous, active low) returns the sequencer to idle, empties
//   the result register and restores the default segment lengths. The
//   frame bytes are rebuilt by every start and need no reset.
module ir_frame_pulse_distance_tx (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [7:0]           i_power_byte,
    input  logic [7:0]           i_mode_byte,
    input  logic [7:0]           i_temp_byte,
    input  logic [7:0]           i_fan_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ir_mark,
    output logic                 o_busy_res,
    output logic                 o_frame_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ifpd_pkg::t_cfg_idx   i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    ifpd_pkg::t_timing    r_timing;
    ifpd_pkg::t_frame_ctl frame_ctl;
    ifpd_pkg::t_result    result;
    ifpd_pkg::t_result    r_out;
    logic                 r_out_valid;
    logic                 in_accept;
    logic                 cur_bit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.hdr_mark   <= ifpd_pkg::RST_HDR_MARK;
            r_timing.hdr_space  <= ifpd_pkg::RST_HDR_SPACE;
            r_timing.bit_mark   <= ifpd_pkg::RST_BIT_MARK;
            r_timing.one_space  <= ifpd_pkg::RST_ONE_SPACE;
            r_timing.zero_space <= ifpd_pkg::RST_ZERO_SPACE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ifpd_pkg::CFG_HDR_MARK:   r_timing.hdr_mark   <= i_cfg_data;
                ifpd_pkg::CFG_HDR_SPACE:  r_timing.hdr_space  <= i_cfg_data;
                ifpd_pkg::CFG_BIT_MARK:   r_timing.bit_mark   <= i_cfg_data;
                ifpd_pkg::CFG_ONE_SPACE:  r_timing.one_space  <= i_cfg_data;
                ifpd_pkg::CFG_ZERO_SPACE: r_timing.zero_space <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ifpd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_accept),
        .i_action    (i_action),
        .i_timing    (r_timing),
        .i_cur_bit   (cur_bit),
        .o_frame_ctl (frame_ctl),
        .o_result    (result)
    );

    ifpd_frame u_frame (
        .i_clk        (i_clk),
        .i_ctl        (frame_ctl),
        .i_power_byte (i_power_byte),
        .i_mode_byte  (i_mode_byte),
        .i_temp_byte  (i_temp_byte),
        .i_fan_byte   (i_fan_byte),
        .o_cur_bit    (cur_bit)
    );

    // Result register: load on every accepted request, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ir_mark    = r_out.ir_mark;
    assign o_busy_res   = r_out.busy_res;
    assign o_frame_done = r_out.frame_done;

endmodule
